/* src/pngunf_pkg.sv */
// Shared constants, types and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; the unfilter and the checker import this package.
package pngunf_pkg;

  // line store and pixel limits
  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int ADDR_W    = $clog2(MAX_ROW_BYTES);
  localparam int COL_W     = $clog2(MAX_ROW_BYTES + 1);
  localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // configuration register widths
  localparam int BPP_W      = 4;
  localparam int ROWB_W     = 14;
  localparam int ROWC_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BYTES_PER_PIXEL = 2'd0,
    REG_ROW_BYTES       = 2'd1,
    REG_ROW_COUNT       = 2'd2
  } reg_idx_t;

  // reset values of the registers
  localparam logic [BPP_W-1:0]  BPP_RESET  = 4'd3;
  localparam logic [ROWB_W-1:0] ROWB_RESET = 14'd3072;
  localparam logic [ROWC_W-1:0] ROWC_RESET = 16'd1;

  // row filter types
  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } filt_t;

  // output status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // paeth predictor: pick the neighbor closest to a + b - c
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] sa, sb, sc, pa, pb, pc;
    logic        [10:0] da, db, dc;
    logic        [7:0]  pick;
    sa = 11'(signed'({3'b000, a}));
    sb = 11'(signed'({3'b000, b}));
    sc = 11'(signed'({3'b000, c}));
    pa = sb - sc;
    pb = sa - sc;
    pc = sa + sb - sc - sc;
    da = (pa < 0) ? 11'(-pa) : 11'(pa);
    db = (pb < 0) ? 11'(-pb) : 11'(pb);
    dc = (pc < 0) ? 11'(-pc) : 11'(pc);
    if (da <= db && da <= dc) begin
      pick = a;
    end else if (db <= dc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

/* src/pngunf_if.sv */
// Valid/ready channel interfaces for the unfilter input and result items.
// No dependencies on other files of the block.
interface pngunf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       image_start;

  modport source (output valid, output raw_byte, output image_start, input ready);
  modport sink   (input valid, input raw_byte, input image_start, output ready);
endinterface

interface pngunf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       status;
  logic       last_of_image;

  modport source (output valid, output pixel_byte, output status, output last_of_image,
                  input ready);
  modport sink   (input valid, input pixel_byte, input status, input last_of_image,
                  output ready);
endinterface

/* src/pngunf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; width and depth come in as parameters.
module pngunf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/png_scanline_unfilter.sv */
// PNG scanline unfilter: rebuilds None/Sub/Up/Average/Paeth filtered bytes.
// A data item's result passes two register stages, the stage 1 register and then the output register.
// Throughput: one item per cycle while the output is not stalled; the registered line store read sets the stage split.
// Filter-type items give no result; a bad filter type gives one error result.
// Reset (rst, synchronous) clears control and histories; the line store keeps
// its contents and the first row of each image reads the row above as zero.
module png_scanline_unfilter
  import pngunf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pngunf_in_if.sink             raw,
  pngunf_out_if.source          pix
);

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_DATA,
    OP_ERROR
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [7:0]           raw_byte;
    filt_t                filt;
    logic                 first;
    logic [ADDR_W-1:0]    addr;
    logic                 last;
    logic [PIX_IDX_W-1:0] pidx;
  } s1_t;

  // configuration registers
  logic [BPP_W-1:0]  bytes_per_pixel;
  logic [ROWB_W-1:0] row_bytes;
  logic [ROWC_W-1:0] row_count;

  // row state
  logic [COL_W-1:0]  col_pos, col_pos_next;
  filt_t             row_filter, row_filter_next;
  logic [ROWC_W-1:0] row_index, row_index_next;
  logic              first_row, first_row_next;
  logic              error_hold, error_hold_next;

  // pipeline
  logic s1_valid;
  s1_t  s1, s1_next;
  logic s1_load;
  logic accept, adv2;

  logic [7:0] left_hist   [MAX_PIXEL_BYTES];
  logic [7:0] upleft_hist [MAX_PIXEL_BYTES];

  logic              ram_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        ram_rdata;
  logic              fwd_hit;
  logic [7:0]        fwd_data;

  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 out_status;
  logic                 out_last;

  // clamped registers and effective state after an image start
  logic [BPP_W-1:0]  bpp_c;
  logic [ROWB_W-1:0] rb_c;
  logic [COL_W-1:0]  col_e;
  logic [ROWC_W-1:0] row_idx_e;
  filt_t             filt_e;
  logic              first_e, err_e;

  // stage 2 datapath
  logic [7:0] a_val, b_val, c_val, pred, v_val;
  logic [8:0] ab_sum;

  assign accept   = raw.valid && raw.ready;
  assign adv2     = s1_valid && (!out_valid || pix.ready);
  assign raw.ready = !s1_valid || adv2;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_RESET;
      row_bytes       <= ROWB_RESET;
      row_count       <= ROWC_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_ROW_BYTES:       row_bytes       <= cfg_data[ROWB_W-1:0];
        REG_ROW_COUNT:       row_count       <= cfg_data[ROWC_W-1:0];
        default: ;
      endcase
    end
  end

  // register clamping
  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_c = BPP_W'(1);
    end else if (32'(bytes_per_pixel) > MAX_PIXEL_BYTES) begin
      bpp_c = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_c = bytes_per_pixel;
    end
    if (row_bytes == '0) begin
      rb_c = ROWB_W'(1);
    end else if (32'(row_bytes) > MAX_ROW_BYTES) begin
      rb_c = ROWB_W'(MAX_ROW_BYTES);
    end else begin
      rb_c = row_bytes;
    end
  end

  // stage 1: row sequencing, filter byte decode, line store address
  always_comb begin
    col_e     = raw.image_start ? '0 : col_pos;
    row_idx_e = raw.image_start ? '0 : row_index;
    filt_e    = raw.image_start ? FLT_NONE : row_filter;
    first_e   = raw.image_start ? 1'b1 : first_row;
    err_e     = raw.image_start ? 1'b0 : error_hold;

    col_pos_next    = col_pos;
    row_index_next  = row_index;
    row_filter_next = row_filter;
    first_row_next  = first_row;
    error_hold_next = error_hold;
    s1_load         = 1'b0;

    rd_addr          = ADDR_W'(col_e - COL_W'(1));
    s1_next.op       = OP_DATA;
    s1_next.raw_byte = raw.raw_byte;
    s1_next.filt     = filt_e;
    s1_next.first    = first_e;
    s1_next.addr     = rd_addr;
    s1_next.last     = 1'b0;
    s1_next.pidx     = PIX_IDX_W'(bpp_c - BPP_W'(1));

    if (accept) begin
      col_pos_next    = col_e;
      row_index_next  = row_idx_e;
      row_filter_next = filt_e;
      first_row_next  = first_e;
      error_hold_next = err_e;
      if (!err_e && row_idx_e < row_count) begin
        s1_load = 1'b1;
        if (col_e == '0) begin
          if (raw.raw_byte > 8'(FLT_PAETH)) begin
            // bad filter type: one error result, then hold until image start
            error_hold_next = 1'b1;
            s1_next.op      = OP_ERROR;
          end else begin
            row_filter_next = filt_t'(raw.raw_byte[2:0]);
            col_pos_next    = COL_W'(1);
            s1_next.op      = OP_CLEAR;
          end
        end else if (32'(col_e) >= 32'(rb_c)) begin
          // last byte of the row
          col_pos_next   = '0;
          first_row_next = 1'b0;
          row_index_next = row_idx_e + ROWC_W'(1);
          s1_next.last   = ((ROWC_W+1)'(row_idx_e) + 1'b1) == (ROWC_W+1)'(row_count);
        end else begin
          col_pos_next = col_e + COL_W'(1);
        end
      end
    end
  end

  // row state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos    <= '0;
      row_index  <= '0;
      row_filter <= FLT_NONE;
      first_row  <= 1'b1;
      error_hold <= 1'b0;
    end else begin
      col_pos    <= col_pos_next;
      row_index  <= row_index_next;
      row_filter <= row_filter_next;
      first_row  <= first_row_next;
      error_hold <= error_hold_next;
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= s1_load;
    end else if (adv2) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // line store: read for the incoming item, write back the rebuilt byte
  assign ram_we = adv2 && (s1.op == OP_DATA);

  pngunf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1.addr),
    .wr_data (v_val),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // forward a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= ram_we && (s1.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= v_val;
    end
  end

  // stage 2: neighbors and prediction
  always_comb begin
    a_val  = left_hist[s1.pidx];
    c_val  = upleft_hist[s1.pidx];
    b_val  = s1.first ? 8'd0 : (fwd_hit ? fwd_data : ram_rdata);
    ab_sum = {1'b0, a_val} + {1'b0, b_val};
    case (s1.filt)
      FLT_NONE:  pred = 8'd0;
      FLT_SUB:   pred = a_val;
      FLT_UP:    pred = b_val;
      FLT_AVG:   pred = ab_sum[8:1];
      FLT_PAETH: pred = paeth_pick(a_val, b_val, c_val);
      default:   pred = 8'd0;
    endcase
    v_val = s1.raw_byte + pred;
  end

  // left and above-left histories, newest first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]   <= 8'd0;
        upleft_hist[i] <= 8'd0;
      end
    end else if (adv2 && s1.op == OP_CLEAR) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]   <= 8'd0;
        upleft_hist[i] <= 8'd0;
      end
    end else if (adv2 && s1.op == OP_DATA) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_hist[i]   <= left_hist[i-1];
        upleft_hist[i] <= upleft_hist[i-1];
      end
      left_hist[0]   <= v_val;
      upleft_hist[0] <= b_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2 && s1.op != OP_CLEAR) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1.op != OP_CLEAR) begin
      if (s1.op == OP_ERROR) begin
        out_byte   <= 8'd0;
        out_status <= STATUS_ERR;
        out_last   <= 1'b0;
      end else begin
        out_byte   <= v_val;
        out_status <= STATUS_OK;
        out_last   <= s1.last;
      end
    end
  end

  assign pix.valid         = out_valid;
  assign pix.pixel_byte    = out_byte;
  assign pix.status        = out_status;
  assign pix.last_of_image = out_last;

endmodule

/* src/pngunf_checker.sv */
// Port-level checks for png_scanline_unfilter, attached by the bind below.
// Depends on pngunf_pkg for the status codes.
module pngunf_checker
  import pngunf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pixel_byte,
  input logic       status,
  input logic       last_of_image
);

  // a result waits until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_byte) && $stable(status)
                                && $stable(last_of_image))
    else $error("stalled result changed");

  // input only backs up behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // an error result carries a zero byte and no end mark
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_ERR |-> pixel_byte == 8'd0 && !last_of_image)
    else $error("error result with payload");

endmodule

bind png_scanline_unfilter pngunf_checker u_pngunf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (raw.ready),
  .out_valid     (pix.valid),
  .out_ready     (pix.ready),
  .pixel_byte    (pix.pixel_byte),
  .status        (pix.status),
  .last_of_image (pix.last_of_image)
);
